### sv/selective_repeat_sender_core_assert.svh
// assertion macros for the selective repeat sender core
`ifndef SELECTIVE_REPEAT_SENDER_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_CORE_ASSERT_SVH

// checked only outside reset
`define SRS_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SRS_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/srs_pkg.sv
// types, constants and helpers shared by the selective repeat sender
`timescale 1ns / 1ps

package srs_pkg;

  localparam int SEQ_SPACE = 12;
  localparam int SEQ_W     = 4;
  localparam int BSUM_W    = 13;
  localparam int PSUM_W    = 14;
  localparam int PAY_W     = 160;

  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef logic [1:0] res_kind_t;
  localparam res_kind_t RES_PLAIN = 2'd0;
  localparam res_kind_t RES_SEND  = 2'd1;
  localparam res_kind_t RES_MEM   = 2'd2;

  typedef struct packed {
    logic      in_ready;
    logic      sum_en;
    logic      store;
    logic      mark;
    logic      slide;
    logic      scan_start;
    logic      scan_step;
    logic      mem_rd;
    logic      load_out;
    res_kind_t res_kind;
    logic [1:0] timer;
    logic      acc;
    logic      last;
  } srs_cmd_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] opcode;
    logic       window_full;
    logic       cnt_zero;
    logic       chk_ok;
    logic       none_unacked;
    logic       slide_more;
    logic       scan_done;
    logic       scan_hit;
    logic       more_after;
    logic       out_free;
  } srs_stat_t;

  function automatic logic [SEQ_W-1:0] seq_sub(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + SEQ_W'(SEQ_SPACE) - b;
    end
    return r;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SEQ_W+1)'(SEQ_SPACE)) begin
      s = s - (SEQ_W+1)'(SEQ_SPACE);
    end
    return s[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
    return (a == SEQ_W'(SEQ_SPACE - 1)) ? '0 : a + 1'b1;
  endfunction

endpackage

### sv/srs_if.sv
// request and result channel interfaces of the selective repeat sender
`timescale 1ns / 1ps

interface srs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [63:0]        payload_low;
  logic [63:0]        payload_mid;
  logic [31:0]        payload_high;
  logic signed [31:0] ack_seq_field;
  logic signed [31:0] ack_number;
  logic signed [31:0] ack_check;

  modport source (output valid, opcode, payload_low, payload_mid, payload_high,
                  ack_seq_field, ack_number, ack_check, input ready);
  modport sink (input valid, opcode, payload_low, payload_mid, payload_high,
                ack_seq_field, ack_number, ack_check, output ready);
endinterface

interface srs_rsp_if;
  logic               valid;
  logic               ready;
  logic               packet_valid;
  logic [3:0]         packet_seq;
  logic signed [13:0] packet_sum;
  logic [63:0]        out_payload_low;
  logic [63:0]        out_payload_mid;
  logic [31:0]        out_payload_high;
  logic [1:0]         timer_action;
  logic               accepted;
  logic               last_result;

  modport source (output valid, packet_valid, packet_seq, packet_sum, out_payload_low,
                  out_payload_mid, out_payload_high, timer_action, accepted,
                  last_result, input ready);
  modport sink (input valid, packet_valid, packet_seq, packet_sum, out_payload_low,
                out_payload_mid, out_payload_high, timer_action, accepted,
                last_result, output ready);
endinterface

### sv/srs_dp.sv
// datapath: request registers, window state, packet store and result register
`timescale 1ns / 1ps

module srs_dp #(
  parameter int WINDOW = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  srs_pkg::srs_cmd_t cmd,
  output srs_pkg::srs_stat_t stat,
  srs_req_if.sink           req,
  srs_rsp_if.source         rsp
);

  localparam int SS  = srs_pkg::SEQ_SPACE;
  localparam int SW  = srs_pkg::SEQ_W;
  localparam int SW1 = SW + 1;
  localparam int BW  = srs_pkg::BSUM_W;
  localparam int PW  = srs_pkg::PSUM_W;
  localparam int EFF_WIN = (WINDOW < SS) ? WINDOW : SS - 1;
  localparam logic [SW-1:0] EFF = SW'(EFF_WIN);

  logic [1:0]  op_q;
  logic [63:0] pay_lo_q;
  logic [63:0] pay_mid_q;
  logic [31:0] pay_hi_q;
  logic [31:0] a_seq_q;
  logic [31:0] a_num_q;
  logic [31:0] a_chk_q;
  logic [BW-1:0] bsum_q;
  logic [32:0] pair_q;

  logic [SW-1:0] base;
  logic [SW-1:0] nxt;
  logic [SS-1:0] acked;
  logic [SW-1:0] scan_i;
  logic [SW-1:0] rd_seq;

  logic [srs_pkg::PAY_W+BW-1:0] mem [SS];
  logic [srs_pkg::PAY_W+BW-1:0] rd_q;

  logic          out_valid;
  logic          o_pv;
  logic [SW-1:0] o_seq;
  logic [PW-1:0] o_sum;
  logic [63:0]   o_lo;
  logic [63:0]   o_mid;
  logic [31:0]   o_hi;
  logic [1:0]    o_timer;
  logic          o_acc;
  logic          o_last;

  logic          accept;
  logic [SW-1:0] cnt;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] ack_n;
  logic          ack_in_win;
  logic [34:0]   chk_calc;
  logic [SS-1:0] unack;
  logic [SS-1:0] above;

  // byte sum as a tree
  logic [srs_pkg::PAY_W-1:0] all_bytes;
  logic [8:0]  l1 [10];
  logic [9:0]  l2 [5];
  logic [10:0] l3a;
  logic [10:0] l3b;
  logic [BW-1:0] bsum;

  assign all_bytes = {pay_hi_q, pay_mid_q, pay_lo_q};

  for (genvar i = 0; i < 10; i++) begin : g_l1
    assign l1[i] = {1'b0, all_bytes[16*i +: 8]} + {1'b0, all_bytes[16*i+8 +: 8]};
  end
  for (genvar i = 0; i < 5; i++) begin : g_l2
    assign l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
  end
  assign l3a  = {1'b0, l2[0]} + {1'b0, l2[1]};
  assign l3b  = {1'b0, l2[2]} + {1'b0, l2[3]};
  assign bsum = BW'(l3a) + BW'(l3b) + BW'(l2[4]);

  assign accept = req.valid && cmd.in_ready;
  assign req.ready = cmd.in_ready;

  assign cnt        = srs_pkg::seq_sub(nxt, base);
  assign rd_addr    = srs_pkg::seq_add(base, scan_i);
  assign ack_n      = a_num_q[SW-1:0];
  assign ack_in_win = (a_num_q < 32'(SS)) && (srs_pkg::seq_sub(ack_n, base) < EFF);
  assign chk_calc   = {{2{pair_q[32]}}, pair_q} + {{(35-BW){1'b0}}, bsum_q};

  // unacked slots by offset from the window base
  for (genvar j = 0; j < SS; j++) begin : g_off
    logic [SW1-1:0] wrap_idx;
    logic [SW1-1:0] off_idx;
    assign wrap_idx = {1'b0, base} + SW1'(j);
    assign off_idx  = (wrap_idx >= SW1'(SS)) ? wrap_idx - SW1'(SS) : wrap_idx;
    assign unack[j] = (SW'(j) < cnt) && !acked[off_idx[SW-1:0]];
    assign above[j] = SW'(j) > scan_i;
  end

  always_comb begin
    stat              = '0;
    stat.accept       = accept;
    stat.opcode       = op_q;
    stat.window_full  = cnt >= EFF;
    stat.cnt_zero     = cnt == '0;
    stat.chk_ok       = chk_calc == {{3{a_chk_q[31]}}, a_chk_q};
    stat.none_unacked = ~|unack;
    stat.slide_more   = (cnt != '0) && acked[base];
    stat.scan_done    = scan_i == cnt;
    stat.scan_hit     = unack[scan_i];
    stat.more_after   = |(unack & above);
    stat.out_free     = !out_valid || rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= req.opcode;
      pay_lo_q  <= req.payload_low;
      pay_mid_q <= req.payload_mid;
      pay_hi_q  <= req.payload_high;
      a_seq_q   <= req.ack_seq_field;
      a_num_q   <= req.ack_number;
      a_chk_q   <= req.ack_check;
    end
    if (cmd.sum_en) begin
      bsum_q <= bsum;
      pair_q <= {a_seq_q[31], a_seq_q} + {a_num_q[31], a_num_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      nxt    <= '0;
      acked  <= '0;
      scan_i <= '0;
    end else begin
      if (cmd.store) begin
        acked[nxt] <= 1'b0;
        nxt        <= srs_pkg::seq_inc(nxt);
      end
      if (cmd.mark && ack_in_win) begin
        acked[ack_n] <= 1'b1;
      end
      if (cmd.slide) begin
        base <= srs_pkg::seq_inc(base);
      end
      if (cmd.scan_start) begin
        scan_i <= '0;
      end else if (cmd.scan_step) begin
        scan_i <= scan_i + 1'b1;
      end
    end
  end

  // packet store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[nxt] <= {bsum_q, pay_hi_q, pay_mid_q, pay_lo_q};
    end
    if (cmd.mem_rd) begin
      rd_q   <= mem[rd_addr];
      rd_seq <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_timer <= cmd.timer;
      o_acc   <= cmd.acc;
      o_last  <= cmd.last;
      case (cmd.res_kind)
        srs_pkg::RES_SEND: begin
          o_pv  <= 1'b1;
          o_seq <= nxt;
          o_sum <= PW'(bsum_q) + PW'(nxt) - PW'(1);
          o_lo  <= pay_lo_q;
          o_mid <= pay_mid_q;
          o_hi  <= pay_hi_q;
        end
        srs_pkg::RES_MEM: begin
          o_pv  <= 1'b1;
          o_seq <= rd_seq;
          o_sum <= PW'(rd_q[srs_pkg::PAY_W +: BW]) + PW'(rd_seq) - PW'(1);
          o_lo  <= rd_q[63:0];
          o_mid <= rd_q[127:64];
          o_hi  <= rd_q[159:128];
        end
        default: begin
          o_pv  <= 1'b0;
          o_seq <= '0;
          o_sum <= '0;
          o_lo  <= '0;
          o_mid <= '0;
          o_hi  <= '0;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.packet_valid     = o_pv;
  assign rsp.packet_seq       = o_seq;
  assign rsp.packet_sum       = o_sum;
  assign rsp.out_payload_low  = o_lo;
  assign rsp.out_payload_mid  = o_mid;
  assign rsp.out_payload_high = o_hi;
  assign rsp.timer_action     = o_timer;
  assign rsp.accepted         = o_acc;
  assign rsp.last_result      = o_last;

endmodule

### sv/srs_ctrl.sv
// controller state machine of the selective repeat sender
`timescale 1ns / 1ps

module srs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  srs_pkg::srs_stat_t stat,
  output srs_pkg::srs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SUM       = 3'd1;
  localparam logic [2:0] S_DISPATCH  = 3'd2;
  localparam logic [2:0] S_SLIDE     = 3'd3;
  localparam logic [2:0] S_OUT_PLAIN = 3'd4;
  localparam logic [2:0] S_OUT_SEND  = 3'd5;
  localparam logic [2:0] S_SCAN      = 3'd6;
  localparam logic [2:0] S_OUT_MEM   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] pend_timer;
  logic [1:0] pend_timer_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_timer <= srs_pkg::TMR_NONE;
    end else begin
      state      <= state_next;
      pend_timer <= pend_timer_next;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.res_kind    = srs_pkg::RES_PLAIN;
    cmd.timer       = srs_pkg::TMR_NONE;
    state_next      = state;
    pend_timer_next = pend_timer;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.accept) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.opcode)
          srs_pkg::OP_SEND: begin
            if (stat.window_full) begin
              pend_timer_next = srs_pkg::TMR_NONE;
              state_next      = S_OUT_PLAIN;
            end else begin
              state_next = S_OUT_SEND;
            end
          end
          srs_pkg::OP_ACK: begin
            if (stat.chk_ok) begin
              cmd.mark   = 1'b1;
              state_next = S_SLIDE;
            end else begin
              pend_timer_next = srs_pkg::TMR_NONE;
              state_next      = S_OUT_PLAIN;
            end
          end
          srs_pkg::OP_TIMEOUT: begin
            if (stat.none_unacked) begin
              pend_timer_next = srs_pkg::TMR_START;
              state_next      = S_OUT_PLAIN;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            pend_timer_next = srs_pkg::TMR_NONE;
            state_next      = S_OUT_PLAIN;
          end
        endcase
      end
      S_SLIDE: begin
        if (stat.slide_more) begin
          cmd.slide = 1'b1;
        end else begin
          pend_timer_next = stat.cnt_zero ? srs_pkg::TMR_STOP : srs_pkg::TMR_RESTART;
          state_next      = S_OUT_PLAIN;
        end
      end
      S_OUT_PLAIN: begin
        cmd.res_kind = srs_pkg::RES_PLAIN;
        cmd.timer    = pend_timer;
        cmd.last     = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_OUT_SEND: begin
        cmd.res_kind = srs_pkg::RES_SEND;
        cmd.timer    = stat.cnt_zero ? srs_pkg::TMR_START : srs_pkg::TMR_NONE;
        cmd.acc      = 1'b1;
        cmd.last     = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.store    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_IDLE;
        end else if (stat.scan_hit) begin
          cmd.mem_rd = 1'b1;
          state_next = S_OUT_MEM;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_OUT_MEM: begin
        cmd.res_kind = srs_pkg::RES_MEM;
        cmd.last     = !stat.more_after;
        cmd.timer    = stat.more_after ? srs_pkg::TMR_NONE : srs_pkg::TMR_START;
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.scan_step = 1'b1;
          state_next    = stat.more_after ? S_SCAN : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/selective_repeat_sender_core.sv
// top level of the selective repeat sender core
//
//   channel | dir | handshake     | carries
//   req     | in  | valid / ready | opcode, payload, ack fields
//   rsp     | out | valid / ready | one result per handshake, last_result on the final one
//
// a request is taken only in the idle state; refused sends, bad acks and unused opcodes get
// a plain result, a send with room is stored and sent, a valid ack marks its slot and slides
// the window base past acked slots; a timeout with unacked packets scans one slot a cycle
// up to the last unacked one, pausing to resend each via the store read port
// reset clears the window pointers and ack flags at once; the packet store needs no clearing
// results sit in an output register; a stalled rsp holds the controller until it drains,
// and the next request may be taken while the last result still waits
`timescale 1ns / 1ps

module selective_repeat_sender_core #(
  parameter int WINDOW = 6
) (
  input logic       clk,
  input logic       rst,
  srs_req_if.sink   req,
  srs_rsp_if.source rsp
);

  srs_pkg::srs_cmd_t  cmd;
  srs_pkg::srs_stat_t stat;

  srs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  srs_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

### sv/srs_checker.sv
// port level checks on the result channel of the selective repeat sender
`timescale 1ns / 1ps
`include "selective_repeat_sender_core_assert.svh"

module srs_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_packet_valid,
  input logic [3:0]  rsp_packet_seq,
  input logic [13:0] rsp_packet_sum,
  input logic [63:0] rsp_lo,
  input logic [63:0] rsp_mid,
  input logic [31:0] rsp_hi,
  input logic [1:0]  rsp_timer,
  input logic        rsp_accepted,
  input logic        rsp_last
);

  `SRS_CHECK_ALWAYS(a_idle_after_reset, rst |=> !rsp_valid, "result valid after reset")

  `SRS_CHECK(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_seq) && $stable(rsp_packet_sum) && $stable(rsp_last), "stalled result changed")

  `SRS_CHECK(a_empty_result, rsp_valid && !rsp_packet_valid |-> (rsp_packet_seq == 4'd0) && (rsp_packet_sum == 14'd0) && (rsp_lo == 64'd0) && (rsp_mid == 64'd0) && (rsp_hi == 32'd0), "result without packet carries data")

  `SRS_CHECK(a_accepted_send, rsp_valid && rsp_accepted |-> rsp_packet_valid && rsp_last && (rsp_packet_seq < 4'(srs_pkg::SEQ_SPACE)), "accepted send malformed")

  `SRS_CHECK(a_resend_body, rsp_valid && !rsp_last |-> rsp_packet_valid && (rsp_timer == srs_pkg::TMR_NONE) && !rsp_accepted, "non final result malformed")

endmodule

bind selective_repeat_sender_core srs_checker u_srs_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_packet_valid (rsp.packet_valid),
  .rsp_packet_seq   (rsp.packet_seq),
  .rsp_packet_sum   (rsp.packet_sum),
  .rsp_lo           (rsp.out_payload_low),
  .rsp_mid          (rsp.out_payload_mid),
  .rsp_hi           (rsp.out_payload_high),
  .rsp_timer        (rsp.timer_action),
  .rsp_accepted     (rsp.accepted),
  .rsp_last         (rsp.last_result)
);
